// File: design/rlbs_pkg.sv
// Shared types and constants for the reserve / bid / round-robin task picker.
// Used by the top level, rlbs_cell and the testbench; no dependencies.
package rlbs_pkg;

   localparam int IDX_W  = 8;   // slot index and list position, up to 256 slots
   localparam int CNT_W  = 8;
   localparam int BID_W  = 16;  // widest bid
   localparam int PCT_W  = 7;
   localparam int PFX_W  = 9;   // reserve prefix sum and lottery draw
   localparam int CHG_W  = 32;
   localparam int SEED_W = 30;
   localparam int OP_W   = 3;
   localparam int SLOT_W = 6;
   localparam int AMT_W  = 10;
   localparam int STAT_W = 2;
   localparam int LVL_W  = 2;
   localparam int REQ_W  = 24;
   localparam int RSP_W  = 80;

   localparam logic [OP_W-1:0] OP_PICK    = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC   = 3'd1;
   localparam logic [OP_W-1:0] OP_RESERVE = 3'd2;
   localparam logic [OP_W-1:0] OP_BID     = 3'd3;
   localparam logic [OP_W-1:0] OP_RUN     = 3'd4;
   localparam logic [OP_W-1:0] OP_FREE    = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE  = 2'd1;
   localparam logic [STAT_W-1:0] ST_BUDGET = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

   localparam logic [LVL_W-1:0] LV_NONE    = 2'd0;
   localparam logic [LVL_W-1:0] LV_RESERVE = 2'd1;
   localparam logic [LVL_W-1:0] LV_BID     = 2'd2;
   localparam logic [LVL_W-1:0] LV_RR      = 2'd3;

   // multiplier 1103515245 reduced mod 2^30; only low product bits matter
   localparam logic [SEED_W-1:0] LCG_MUL   = 30'd29773421;
   localparam logic [SEED_W-1:0] LCG_ADD   = 30'd12345;
   localparam logic [SEED_W-1:0] SEED_INIT = 30'd100;

   localparam logic [32:0]      NANO_PER_BID   = 33'd25;
   localparam logic [CHG_W-1:0] NANO_PER_MICRO = 32'd1000;
   localparam logic [AMT_W-1:0] PERCENT_MAX    = 10'd100;

   typedef struct packed {
      logic [PFX_W-1:0] num;
      logic [IDX_W-1:0] rr_next;
      logic [IDX_W-1:0] slot;
      logic [BID_W-1:0] amount;
   } query_type;

   typedef struct packed {
      logic [PFX_W-1:0] prefix;
      logic             lot_hit;
      logic [IDX_W-1:0] lot_slot;
      logic             bid_hit;
      logic [IDX_W-1:0] bid_pos;
      logic [IDX_W-1:0] bid_slot;
      logic [BID_W-1:0] bid_val;
      logic             rrh_hit;
      logic [IDX_W-1:0] rrh_slot;
      logic             rrl_hit;
      logic [IDX_W-1:0] rrl_slot;
      logic             t_use;
      logic [PCT_W-1:0] t_pct;
      logic [BID_W-1:0] t_bid;
      logic [IDX_W-1:0] t_pos;
      logic [CNT_W-1:0] cnt_gt;
      logic [CNT_W-1:0] cnt_ge;
   } sweep_type;

   typedef struct packed {
      logic             en;
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] slot;
      logic [BID_W-1:0] amount;
      logic             flag;
      logic [IDX_W-1:0] tpos;
      logic [IDX_W-1:0] rank;
      logic             remove;
      logic             insert;
   } cmd_type;

endpackage

// File: design/reserve_lottery_bid_scheduler_unit.sv
// Reserve / bid / round-robin task picker, top level.
// Uses rlbs_pkg, rlbs_cell (one per slot) and rlbs_ram (per-slot charge counters).
//
// Channels: one request beat in (req_), one response beat out (rsp_) per request.
// Ops: pick, allocate, reserve percent, spot bid, set runnable, free.
// A request is taken only while the block is idle; the response register
// lets the next request in while the previous response is still waiting.
// Every request but a bad op or slot sweeps one beat down the row of SLOTS cells, one cell a cycle,
// gathering lottery, bid-list, round-robin and target-slot facts.
// Steps: ops other than pick launch the sweep and then commit; pick adds an
// LCG step and a reciprocal quotient and remainder before the sweep, and a
// counter read and update after it, both skipped when nothing is runnable.
// A bad op or slot answers without a sweep. A new request is taken only
// once the previous one is finished; the cell sweep sets the pace.
// Reset: all slots free, lists empty, seed 100; counters read as zero
// through per-slot valid bits, so no clearing pass runs.
// A stalled receiver holds the response; the block finishes the current
// request and then waits for the response register to empty.
module reserve_lottery_bid_scheduler_unit
   import rlbs_pkg::*;
#(
   parameter int SLOTS         = 64,
   parameter int RESERVE_SLOTS = 200,
   parameter int BID_BITS      = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // slot[5:0], amount[15:6], runnable_flag[16], zeros
   input  logic [OP_W-1:0]  req_tuser,  // op[2:0]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // status[1:0], found[2], level[4:3],
                                        // picked_slot[10:5], cost_micro[42:11],
                                        // chosen_count[74:43], zeros
);

   localparam int AW        = $clog2(SLOTS);
   localparam int BID_LIMIT = 1 << BID_BITS;
   localparam int WORD_W    = 3 * CHG_W;
   // seed / RESERVE_SLOTS by reciprocal; exact for any seed below 2^30
   localparam int          RCP_SH  = 38;
   localparam int          QUOT_W  = 24;
   localparam logic [31:0] RCP_MUL = 32'(((64'd1 << RCP_SH) + 64'(RESERVE_SLOTS) - 64'd1)
                                         / 64'(RESERVE_SLOTS));

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LCG    = 4'd1;
   localparam logic [3:0] S_MOD    = 4'd2;
   localparam logic [3:0] S_LAUNCH = 4'd3;
   localparam logic [3:0] S_SWEEP  = 4'd4;
   localparam logic [3:0] S_COMMIT = 4'd5;
   localparam logic [3:0] S_PICK   = 4'd6;
   localparam logic [3:0] S_CHARGE = 4'd7;
   localparam logic [3:0] S_WRITE  = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;
   localparam logic [3:0] S_REM    = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [AMT_W-1:0]  amount_ff, amount_in;
   logic              flag_ff, flag_in;
   logic [SEED_W-1:0] seed_ff, seed_in;
   logic [PFX_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [IDX_W-1:0]  rr_ff, rr_in;
   logic [PFX_W-1:0]  total_ff, total_in;
   sweep_type         sweep_ff, sweep_in;
   logic [IDX_W-1:0]  pick_slot_ff, pick_slot_in;
   logic [LVL_W-1:0]  pick_lvl_ff, pick_lvl_in;
   logic [BID_W-1:0]  pick_bid_ff, pick_bid_in;
   logic              cvalid_rd_ff, cvalid_rd_in;
   logic [CHG_W-1:0]  micro_ff, micro_in;
   logic [CHG_W-1:0]  nano_ff, nano_in;
   logic [CHG_W-1:0]  chosen_ff, chosen_in;
   logic [STAT_W-1:0] res_status_ff, res_status_in;
   logic              res_found_ff, res_found_in;
   logic [LVL_W-1:0]  res_level_ff, res_level_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [CHG_W-1:0]  res_micro_ff, res_micro_in;
   logic [CHG_W-1:0]  res_chosen_ff, res_chosen_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [SLOTS-1:0]  cnt_valid_ff, cnt_valid_in;

   logic              launch;
   query_type         query;
   cmd_type           cmd;
   sweep_type         chain_acc [SLOTS+1];
   logic              chain_vld [SLOTS+1];

   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [WORD_W-1:0] ram_wr_data, ram_rd_data;

   logic [61:0]       quot_prod;
   logic [IDX_W-1:0]  win_slot;
   logic [LVL_W-1:0]  win_lvl;
   logic [BID_W-1:0]  win_bid;
   logic [CHG_W-1:0]  rd_micro, rd_nano, rd_chosen;
   logic [32:0]       nano_sum;
   logic [CHG_W-1:0]  micro_new, nano_new;

   assign query.num     = rem_ff;
   assign query.rr_next = rr_ff;
   assign query.slot    = IDX_W'(slot_ff);
   // allocation ranks against bid 0: placed after every listed entry
   assign query.amount  = (op_ff == OP_ALLOC) ? '0 : BID_W'(amount_ff);

   assign chain_acc[0] = '0;
   assign chain_vld[0] = launch;

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      rlbs_cell #(.IDX(k)) u_cell (
         .clock         (clock),
         .reset         (reset),
         .acc_valid_in  (chain_vld[k]),
         .acc_in        (chain_acc[k]),
         .query         (query),
         .cmd           (cmd),
         .acc_valid_out (chain_vld[k+1]),
         .acc_out       (chain_acc[k+1])
      );
   end

   rlbs_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_counters (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign quot_prod = 62'(seed_ff) * 62'(RCP_MUL);

   // level order: lottery, then first runnable bidder, then round robin
   always_comb begin
      win_slot = '0;
      win_lvl  = LV_NONE;
      win_bid  = sweep_ff.bid_val;
      priority if (sweep_ff.lot_hit) begin
         win_slot = sweep_ff.lot_slot;
         win_lvl  = LV_RESERVE;
      end else if (sweep_ff.bid_hit) begin
         win_slot = sweep_ff.bid_slot;
         win_lvl  = LV_BID;
      end else if (sweep_ff.rrh_hit) begin
         win_slot = sweep_ff.rrh_slot;
         win_lvl  = LV_RR;
      end else if (sweep_ff.rrl_hit) begin
         win_slot = sweep_ff.rrl_slot;
         win_lvl  = LV_RR;
      end else begin
         win_lvl  = LV_NONE;
      end
   end

   assign rd_micro  = cvalid_rd_ff ? ram_rd_data[CHG_W-1:0] : '0;
   assign rd_nano   = cvalid_rd_ff ? ram_rd_data[2*CHG_W-1:CHG_W] : '0;
   assign rd_chosen = cvalid_rd_ff ? ram_rd_data[3*CHG_W-1:2*CHG_W] : '0;
   assign nano_sum  = 33'(rd_nano) + 33'(pick_bid_ff) * NANO_PER_BID;

   always_comb begin
      micro_new = micro_ff;
      nano_new  = nano_ff;
      if (pick_lvl_ff == LV_BID && nano_ff > NANO_PER_MICRO) begin
         micro_new = micro_ff + CHG_W'(1);
         nano_new  = nano_ff - NANO_PER_MICRO;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      amount_in     = amount_ff;
      flag_in       = flag_ff;
      seed_in       = seed_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      rr_in         = rr_ff;
      total_in      = total_ff;
      sweep_in      = sweep_ff;
      pick_slot_in  = pick_slot_ff;
      pick_lvl_in   = pick_lvl_ff;
      pick_bid_in   = pick_bid_ff;
      cvalid_rd_in  = cvalid_rd_ff;
      micro_in      = micro_ff;
      nano_in       = nano_ff;
      chosen_in     = chosen_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_level_in  = res_level_ff;
      res_slot_in   = res_slot_ff;
      res_micro_in  = res_micro_ff;
      res_chosen_in = res_chosen_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      cnt_valid_in  = cnt_valid_ff;
      launch        = 1'b0;
      cmd           = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = AW'(pick_slot_ff);
      ram_wr_data   = {chosen_ff, nano_new, micro_new};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = AW'(win_slot);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in         = req_tuser;
               slot_in       = req_tdata[5:0];
               amount_in     = req_tdata[15:6];
               flag_in       = req_tdata[16];
               res_status_in = ST_OK;
               res_found_in  = 1'b0;
               res_level_in  = LV_NONE;
               res_slot_in   = '0;
               res_micro_in  = '0;
               res_chosen_in = '0;
               if (req_tuser == OP_PICK) begin
                  state_in = S_LCG;
               end else if (req_tuser > OP_FREE || 9'(req_tdata[5:0]) >= 9'(SLOTS)) begin
                  res_status_in = ST_RANGE;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_LAUNCH;
               end
            end
         end
         S_LCG: begin
            seed_in  = LCG_MUL * seed_ff + LCG_ADD;
            state_in = S_MOD;
         end
         S_MOD: begin
            quot_in  = quot_prod[RCP_SH +: QUOT_W];
            state_in = S_REM;
         end
         S_REM: begin
            rem_in   = PFX_W'(seed_ff - SEED_W'(quot_ff) * SEED_W'(RESERVE_SLOTS));
            state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            launch   = 1'b1;
            state_in = S_SWEEP;
         end
         S_SWEEP: begin
            if (chain_vld[SLOTS]) begin
               sweep_in = chain_acc[SLOTS];
               state_in = (op_ff == OP_PICK) ? S_PICK : S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.op     = op_ff;
            cmd.slot   = IDX_W'(slot_ff);
            cmd.amount = BID_W'(amount_ff);
            cmd.flag   = flag_ff;
            cmd.tpos   = sweep_ff.t_pos;
            state_in   = S_DONE;
            if (op_ff == OP_ALLOC) begin
               if (sweep_ff.t_use) begin
                  res_status_in = ST_RANGE;
               end else begin
                  cmd.en      = 1'b1;
                  cmd.insert  = 1'b1;
                  cmd.rank    = sweep_ff.cnt_ge;
                  cnt_valid_in[AW'(slot_ff)] = 1'b0;
               end
            end else if (!sweep_ff.t_use) begin
               res_status_in = ST_RANGE;
            end else begin
               unique case (op_ff)
                  OP_RESERVE: begin
                     if (amount_ff == '0 || amount_ff > PERCENT_MAX) begin
                        res_status_in = ST_RANGE;
                     end else if (11'(total_ff) + 11'(amount_ff) > 11'(RESERVE_SLOTS)) begin
                        res_status_in = ST_BUDGET;
                     end else begin
                        cmd.en     = 1'b1;
                        cmd.remove = (sweep_ff.t_pct == '0);
                        total_in   = total_ff - PFX_W'(sweep_ff.t_pct) + PFX_W'(amount_ff);
                     end
                  end
                  OP_BID: begin
                     if (int'(amount_ff) >= BID_LIMIT) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        cmd.en     = 1'b1;
                        cmd.insert = 1'b1;
                        if (sweep_ff.t_pct != '0) begin
                           cmd.rank = sweep_ff.cnt_ge;
                           total_in = total_ff - PFX_W'(sweep_ff.t_pct);
                        end else begin
                           // re-place: after equal bids when raised, before them when lowered
                           cmd.remove = 1'b1;
                           priority if (cmd.amount > sweep_ff.t_bid) begin
                              cmd.rank = sweep_ff.cnt_ge;
                           end else if (cmd.amount < sweep_ff.t_bid) begin
                              cmd.rank = sweep_ff.cnt_gt;
                           end else begin
                              cmd.rank = sweep_ff.t_pos;
                           end
                        end
                     end
                  end
                  OP_RUN: begin
                     cmd.en = 1'b1;
                  end
                  OP_FREE: begin
                     cmd.en     = 1'b1;
                     cmd.remove = (sweep_ff.t_pct == '0);
                     total_in   = total_ff - PFX_W'(sweep_ff.t_pct);
                     cnt_valid_in[AW'(slot_ff)] = 1'b0;
                  end
                  default: begin
                     res_status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_PICK: begin
            if (win_lvl == LV_NONE) begin
               state_in = S_DONE;
            end else begin
               pick_slot_in = win_slot;
               pick_lvl_in  = win_lvl;
               pick_bid_in  = win_bid;
               ram_rd_en    = 1'b1;
               cvalid_rd_in = cnt_valid_ff[AW'(win_slot)];
               if (win_lvl == LV_RR) begin
                  rr_in = (win_slot == IDX_W'(SLOTS - 1)) ? '0 : win_slot + IDX_W'(1);
               end
               state_in = S_CHARGE;
            end
         end
         S_CHARGE: begin
            chosen_in = rd_chosen + CHG_W'(1);
            micro_in  = (pick_lvl_ff == LV_RESERVE) ? rd_micro + CHG_W'(1) : rd_micro;
            nano_in   = rd_nano;
            if (pick_lvl_ff == LV_BID) begin
               nano_in = nano_sum[32] ? '1 : nano_sum[CHG_W-1:0];
            end
            state_in = S_WRITE;
         end
         S_WRITE: begin
            ram_wr_en     = 1'b1;
            cnt_valid_in[AW'(pick_slot_ff)] = 1'b1;
            res_found_in  = 1'b1;
            res_level_in  = pick_lvl_ff;
            res_slot_in   = SLOT_W'(pick_slot_ff);
            res_micro_in  = micro_new;
            res_chosen_in = chosen_ff;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({res_chosen_ff, res_micro_ff, res_slot_ff,
                                      res_level_ff, res_found_ff, res_status_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seed_ff      <= SEED_INIT;
         rr_ff        <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         rr_ff        <= rr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_valid_ff <= cnt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      amount_ff     <= amount_in;
      flag_ff       <= flag_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      sweep_ff      <= sweep_in;
      pick_slot_ff  <= pick_slot_in;
      pick_lvl_ff   <= pick_lvl_in;
      pick_bid_ff   <= pick_bid_in;
      cvalid_rd_ff  <= cvalid_rd_in;
      micro_ff      <= micro_in;
      nano_ff       <= nano_in;
      chosen_ff     <= chosen_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_level_ff  <= res_level_in;
      res_slot_ff   <= res_slot_in;
      res_micro_ff  <= res_micro_in;
      res_chosen_ff <= res_chosen_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: design/rlbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rlbs_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/rlbs_cell.sv
// One slot cell: holds the slot's flags, percent, bid and bid-list position,
// folds its part into the sweep beat passing by, and applies commits. Uses rlbs_pkg.
module rlbs_cell
   import rlbs_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      acc_valid_in,
   input  sweep_type acc_in,
   input  query_type query,
   input  cmd_type   cmd,
   output logic      acc_valid_out,
   output sweep_type acc_out
);

   logic             use_ff, use_in;
   logic             run_ff, run_in;
   logic [PCT_W-1:0] pct_ff, pct_in;
   logic [BID_W-1:0] bid_ff, bid_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic             acc_valid_ff;
   sweep_type        acc_ff, acc_in_nxt;

   logic [IDX_W-1:0] me;
   logic             in_list, is_tgt, is_cmd_tgt;
   logic [PFX_W-1:0] top;
   logic [IDX_W-1:0] pos_rm, pos_ins;

   assign me         = IDX_W'(IDX);
   assign in_list    = use_ff && (pct_ff == '0);
   assign is_tgt     = (query.slot == me);
   assign is_cmd_tgt = (cmd.slot == me);
   assign top        = acc_in.prefix + PFX_W'(pct_ff);

   always_comb begin
      acc_in_nxt        = acc_in;
      acc_in_nxt.prefix = top;
      // lottery: this slot owns entries [prefix, prefix+pct)
      if (pct_ff != '0 && run_ff && query.num >= acc_in.prefix && query.num < top) begin
         acc_in_nxt.lot_hit  = 1'b1;
         acc_in_nxt.lot_slot = me;
      end
      if (in_list && run_ff && (!acc_in.bid_hit || pos_ff < acc_in.bid_pos)) begin
         acc_in_nxt.bid_hit  = 1'b1;
         acc_in_nxt.bid_pos  = pos_ff;
         acc_in_nxt.bid_slot = me;
         acc_in_nxt.bid_val  = bid_ff;
      end
      if (run_ff && me >= query.rr_next && !acc_in.rrh_hit) begin
         acc_in_nxt.rrh_hit  = 1'b1;
         acc_in_nxt.rrh_slot = me;
      end
      if (run_ff && !acc_in.rrl_hit) begin
         acc_in_nxt.rrl_hit  = 1'b1;
         acc_in_nxt.rrl_slot = me;
      end
      if (is_tgt) begin
         acc_in_nxt.t_use = use_ff;
         acc_in_nxt.t_pct = pct_ff;
         acc_in_nxt.t_bid = bid_ff;
         acc_in_nxt.t_pos = pos_ff;
      end
      // ranks for list insertion, target excluded
      if (in_list && !is_tgt) begin
         if (bid_ff > query.amount) begin
            acc_in_nxt.cnt_gt = acc_in.cnt_gt + CNT_W'(1);
         end
         if (bid_ff >= query.amount) begin
            acc_in_nxt.cnt_ge = acc_in.cnt_ge + CNT_W'(1);
         end
      end
   end

   assign pos_rm  = (cmd.remove && pos_ff > cmd.tpos) ? pos_ff - IDX_W'(1) : pos_ff;
   assign pos_ins = (cmd.insert && pos_rm >= cmd.rank) ? pos_rm + IDX_W'(1) : pos_rm;

   always_comb begin
      use_in = use_ff;
      run_in = run_ff;
      pct_in = pct_ff;
      bid_in = bid_ff;
      pos_in = pos_ff;
      if (cmd.en) begin
         pos_in = pos_ins;
         if (is_cmd_tgt) begin
            unique case (cmd.op)
               OP_ALLOC: begin
                  use_in = 1'b1;
                  run_in = 1'b0;
                  pct_in = '0;
                  bid_in = '0;
                  pos_in = cmd.rank;
               end
               OP_RESERVE: begin
                  bid_in = '0;
                  pct_in = cmd.amount[PCT_W-1:0];
               end
               OP_BID: begin
                  pct_in = '0;
                  bid_in = cmd.amount;
                  pos_in = cmd.rank;
               end
               OP_RUN: begin
                  run_in = cmd.flag;
               end
               OP_FREE: begin
                  use_in = 1'b0;
                  run_in = 1'b0;
                  pct_in = '0;
                  bid_in = '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ff       <= 1'b0;
         run_ff       <= 1'b0;
         pct_ff       <= '0;
         bid_ff       <= '0;
         pos_ff       <= '0;
         acc_valid_ff <= 1'b0;
      end else begin
         use_ff       <= use_in;
         run_ff       <= run_in;
         pct_ff       <= pct_in;
         bid_ff       <= bid_in;
         pos_ff       <= pos_in;
         acc_valid_ff <= acc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in_nxt;
   end

   assign acc_valid_out = acc_valid_ff;
   assign acc_out       = acc_ff;

endmodule

// File: design/rlbs_checker.sv
// Port-level checks for the task picker, bound to the top level.
// Sees only the response port and reset; no package dependency.
module rlbs_props (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   a_found_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2] == (rsp_tdata[4:3] != 2'd0)))
      else $error("found flag disagrees with level");

   a_status_nopick: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != 2'd0 |-> !rsp_tdata[2])
      else $error("failed op reports a pick");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[74:5] == 70'd0)
      else $error("pick fields not zero without a pick");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind reserve_lottery_bid_scheduler_unit rlbs_props u_rlbs_props (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/rlbs_checker.sv
`timescale 1ns / 1ps
// Checker for the reserve / bid / round-robin task picker: watches both channels,
// predicts every response from its own model of the slot tables and compares.
module rlbs_checker
   import rlbs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic [OP_W-1:0]  req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               fail_count,
   output int               pending
);
   localparam int NS = 64;
   localparam int NR = 200;

   logic [RSP_W-1:0] rsp_queue[$];

   logic [SEED_W-1:0] seed;
   logic              tab_valid[NR];
   int                tab_slot[NR];
   int                total_pct;
   int                order[NS];
   int                order_len;
   int                rr_next;
   logic              in_use[NS];
   logic              runnable[NS];
   int                pct[NS];
   logic [31:0]       bid[NS];
   logic [31:0]       micro[NS];
   logic [31:0]       nano[NS];
   logic [31:0]       chosen[NS];

   assign pending = rsp_queue.size();

   function automatic int find_bidder(int s);
      for (int i = 0; i < order_len; i++)
         if (order[i] == s) return i;
      return -1;
   endfunction

   function automatic void swap_pos(int a, int b);
      int t;
      t = order[a]; order[a] = order[b]; order[b] = t;
   endfunction

   function automatic void sift_left(int p);
      for (int j = p; j > 0; j--)
         if (bid[order[j]] > bid[order[j-1]]) swap_pos(j, j - 1);
   endfunction

   function automatic void sift_right(int p);
      for (int j = p; j + 1 < order_len; j++)
         if (bid[order[j]] < bid[order[j+1]]) swap_pos(j, j + 1);
   endfunction

   function automatic bit add_bidder(int s);
      if (order_len >= NS) return 0;
      order[order_len] = s;
      order_len++;
      sift_left(order_len - 1);
      return 1;
   endfunction

   function automatic void drop_bidder(int s);
      int p;
      p = find_bidder(s);
      if (p < 0) return;
      for (int j = p; j + 1 < order_len; j++) order[j] = order[j+1];
      order_len--;
   endfunction

   function automatic void refill_table();
      int k;
      k = 0;
      total_pct = 0;
      for (int i = 0; i < NR; i++) begin
         tab_valid[i] = 0;
         tab_slot[i] = 0;
      end
      for (int s = 0; s < NS; s++) begin
         total_pct += pct[s];
         for (int j = 0; j < pct[s] && k < NR; j++) begin
            tab_valid[k] = 1;
            tab_slot[k] = s;
            k++;
         end
      end
   endfunction

   function automatic void wipe_slot(int s);
      runnable[s] = 0; pct[s] = 0; bid[s] = 0;
      micro[s] = 0; nano[s] = 0; chosen[s] = 0;
   endfunction

   function automatic void reset_tables();
      seed = SEED_INIT;
      order_len = 0;
      rr_next = 0;
      for (int s = 0; s < NS; s++) begin
         in_use[s] = 0;
         wipe_slot(s);
         order[s] = 0;
      end
      refill_table();
   endfunction

   function automatic logic [RSP_W-1:0] schedule_step(logic [OP_W-1:0] op, int s,
                                                      int amt, logic flag);
      logic [STAT_W-1:0] st;
      logic [LVL_W-1:0]  lvl;
      int                num, pick, p;
      logic [33:0]       n;
      logic              up;
      st = ST_OK;
      lvl = LV_NONE;
      pick = 0;
      if (op == OP_PICK) begin
         seed = seed * LCG_MUL + LCG_ADD;
         num = int'(seed) % NR;
         if (tab_valid[num] && runnable[tab_slot[num]]) begin
            pick = tab_slot[num]; lvl = LV_RESERVE;
         end
         for (int i = 0; lvl == LV_NONE && i < order_len; i++)
            if (runnable[order[i]]) begin
               pick = order[i]; lvl = LV_BID;
            end
         for (int i = 0; lvl == LV_NONE && i < NS; i++)
            if (runnable[(rr_next + i) % NS]) begin
               pick = (rr_next + i) % NS; lvl = LV_RR;
               rr_next = (pick + 1) % NS;
            end
         if (lvl == LV_NONE) return '0;
         chosen[pick] += 1;
         if (lvl == LV_RESERVE) micro[pick] += 1;
         else if (lvl == LV_BID) begin
            n = {2'b0, nano[pick]} + 34'd25 * bid[pick];
            if (n > 34'hFFFF_FFFF) n = 34'hFFFF_FFFF;
            if (n > 34'd1000) begin
               micro[pick] += 1;
               n -= 34'd1000;
            end
            nano[pick] = n[31:0];
         end
         return {chosen[pick], micro[pick], pick[5:0], lvl, 1'b1, ST_OK};
      end
      if (op > OP_FREE) return {{(RSP_W-STAT_W){1'b0}}, ST_RANGE};
      if (op == OP_ALLOC) begin
         if (in_use[s]) st = ST_RANGE;
         else begin
            in_use[s] = 1;
            wipe_slot(s);
            drop_bidder(s);
            if (!add_bidder(s)) st = ST_FULL;
         end
      end else if (!in_use[s]) st = ST_RANGE;
      else if (op == OP_RESERVE) begin
         if (amt == 0 || amt > 100) st = ST_RANGE;
         else if (total_pct + amt > NR) st = ST_BUDGET;
         else begin
            drop_bidder(s);
            bid[s] = 0;
            pct[s] = amt;
            refill_table();
         end
      end else if (op == OP_BID) begin
         if (pct[s] > 0) begin
            pct[s] = 0;
            refill_table();
            bid[s] = amt;
            if (find_bidder(s) < 0 && !add_bidder(s)) st = ST_FULL;
         end else begin
            p = find_bidder(s);
            up = amt > bid[s];
            bid[s] = amt;
            if (p < 0) begin
               if (!add_bidder(s)) st = ST_FULL;
            end else if (up) sift_left(p);
            else sift_right(p);
         end
      end else if (op == OP_RUN) runnable[s] = flag;
      else begin
         up = pct[s] > 0;
         drop_bidder(s);
         in_use[s] = 0;
         wipe_slot(s);
         if (up) refill_table();
      end
      return {{(RSP_W-STAT_W){1'b0}}, st};
   endfunction

   initial reset_tables();

   always @(posedge clock) begin
      logic [RSP_W-1:0] want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            rsp_queue.push_back(schedule_step(req_tuser, int'(req_tdata[5:0]),
                                              int'(req_tdata[15:6]), req_tdata[16]));
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_queue.size() == 0) begin
               $display("%0t: response beat with nothing expected: %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = rsp_queue.pop_front();
               if (want[74:0] !== rsp_tdata[74:0] || rsp_tdata[RSP_W-1:75] !== '0) begin
                  $display("%0t: mismatch expected st=%0d fd=%0d lv=%0d sl=%0d mc=%0d ch=%0d",
                           $time, want[1:0], want[2], want[4:3], want[10:5], want[42:11],
                           want[74:43]);
                  $display("%0t:          actual st=%0d fd=%0d lv=%0d sl=%0d mc=%0d ch=%0d",
                           $time, rsp_tdata[1:0], rsp_tdata[2], rsp_tdata[4:3],
                           rsp_tdata[10:5], rsp_tdata[42:11], rsp_tdata[74:43]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the reserve / bid / round-robin task picker.
// Depends on rlbs_pkg, the block and rlbs_checker.
module testbench
   import rlbs_pkg::*;
;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]  req_tuser = OP_PICK;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   int               fail_count, pending;
   int               send_idle = 0, recv_stall = 0;
   int               quiet = 0;

   always #1 clock = ~clock;

   reserve_lottery_bid_scheduler_unit u_top (.*);

   rlbs_checker u_chk (.*);

   // receiver stall pattern
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall);

   // watchdog on cycles with no beat moved
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("reserve_lottery_bid_scheduler_unit regression: fail");
         $finish;
      end
   end

   // valid stays up between back-to-back beats; it drops only in idle cycles
   task automatic send_beat(logic [OP_W-1:0] op, int s, int amt, logic flag);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, flag, amt[9:0], s[5:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // mostly meaningful traffic over a handful of slots, some noise
   task automatic random_beat();
      int r, s;
      logic [OP_W-1:0] op;
      r = $urandom_range(99);
      s = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7);
      if (r < 30) op = OP_PICK;
      else if (r < 42) op = OP_ALLOC;
      else if (r < 55) op = OP_RESERVE;
      else if (r < 70) op = OP_BID;
      else if (r < 88) op = OP_RUN;
      else if (r < 96) op = OP_FREE;
      else op = OP_W'($urandom_range(7));
      send_beat(op, s, (op == OP_RESERVE && $urandom_range(3) != 0) ?
                $urandom_range(110) : $urandom_range(1023), 1'($urandom_range(1)));
   endtask

   initial begin
      int n;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, errors, each pick level, budget checks
      send_beat(OP_PICK, 0, 0, 0);
      send_beat(OP_RUN, 5, 0, 1);
      send_beat(OP_ALLOC, 0, 0, 0);
      send_beat(OP_ALLOC, 0, 0, 0);
      send_beat(OP_ALLOC, 63, 1023, 1);
      send_beat(OP_RUN, 0, 0, 1);
      send_beat(OP_PICK, 0, 0, 0);
      send_beat(OP_BID, 63, 1023, 0);
      send_beat(OP_RUN, 63, 0, 1);
      send_beat(OP_PICK, 0, 0, 0);
      send_beat(OP_PICK, 0, 0, 0);
      send_beat(OP_RESERVE, 0, 0, 0);
      send_beat(OP_RESERVE, 0, 101, 0);
      send_beat(OP_RESERVE, 0, 100, 0);
      send_beat(OP_RESERVE, 63, 100, 0);
      send_beat(OP_RESERVE, 63, 1, 0);
      send_beat(OP_PICK, 0, 0, 0);
      send_beat(OP_PICK, 0, 0, 0);
      send_beat(OP_BID, 0, 0, 0);
      send_beat(OP_RUN, 0, 0, 0);
      send_beat(OP_FREE, 63, 0, 0);
      send_beat(OP_FREE, 63, 0, 0);
      send_beat(3'd6, 1, 0, 0);
      send_beat(3'd7, 1, 0, 0);
      send_beat(OP_PICK, 0, 0, 0);
      for (int ph = 0; ph < 4; ph++) begin
         send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 68 : 7) : 0;
         recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 68 : 7) : 0;
         n = 0;
         while (n < 140) begin
            random_beat();
            n++;
         end
      end
      // fill the bid list to capacity then hit it again
      send_idle = 0;
      recv_stall = 0;
      for (int s = 0; s < 64; s++) send_beat(OP_ALLOC, s, 0, 0);
      for (int s = 0; s < 64; s += 9) send_beat(OP_BID, s, $urandom_range(1023), 0);
      send_beat(OP_RUN, 9, 0, 1);
      send_beat(OP_PICK, 0, 0, 0);
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("reserve_lottery_bid_scheduler_unit regression: pass");
      else
         $display("reserve_lottery_bid_scheduler_unit regression: fail");
      $finish;
   end
endmodule
